// ===== rtl/core/horton_infiltration_cell_core_macros.svh =====
// ---------------------------------------------------------------------------
// horton infiltration cell core assertion macros
// shared property forms clocked on aclk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef HORTON_INFILTRATION_CELL_CORE_MACROS_SVH
`define HORTON_INFILTRATION_CELL_CORE_MACROS_SVH

// same-cycle implication
`define HIC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hic assertion failed");

// next-cycle implication
`define HIC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hic assertion failed");

`endif

// ===== rtl/core/hic_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hic_pkg
// shared types and constants of the horton infiltration cell core
// ---------------------------------------------------------------------------
package hic_pkg;

    typedef enum logic [1:0] {
        CFG_ENABLED   = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_DRY_DEPTH = 2'd2
    } cfg_idx_t;

    localparam int HORNER_TERMS  = 12;
    localparam int HORNER_STAGES = 3 * HORNER_TERMS;
    localparam int SQUARE_STAGES = 10;
    localparam int EXP_STAGES    = HORNER_STAGES + SQUARE_STAGES;
    localparam int DIV_STEPS     = 33;

    localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
    localparam logic [79:0] EXP_LIMIT = 80'd24 << 48;

    // floor((2^32-1)/i)
    localparam logic [31:0] HORNER_RECIP [1:12] = '{
        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555, 32'h3FFF_FFFF,
        32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924, 32'h1FFF_FFFF,
        32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174, 32'h1555_5555
    };

    typedef struct packed {
        logic               skip;
        logic signed [47:0] z;
        logic [47:0]        h;
        logic [31:0]        ks;
        logic [31:0]        mag;
        logic               dneg;
        logic [47:0]        wt;
    } cell_t;

    typedef struct packed {
        cell_t       info;
        logic [31:0] kd;
        logic [47:0] tw;
    } item_t;

    typedef struct packed {
        logic        big;
        logic [30:0] u;
        logic [63:0] acc;
        logic [31:0] aux;
        cell_t       info;
    } exp_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] num;
        logic [32:0] quo;
        logic        skip;
        logic        sat;
        logic [47:0] surf;
        logic [46:0] depth;
        logic        dry;
        logic [47:0] wt;
    } div_st_t;

endpackage

// ===== rtl/core/hic_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hic_front
// input register, skip classification and per-cell precompute
// ---------------------------------------------------------------------------
module hic_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                enabled,
    input  logic [31:0]         time_step,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [47:0]  s_surface_level,
    input  logic signed [47:0]  s_bed_level,
    input  logic [31:0]         s_sat_conductivity,
    input  logic [31:0]         s_initial_rate,
    input  logic [31:0]         s_decay_const,
    input  logic [47:0]         s_wet_time,
    input  logic                s_weir_cell,
    output logic                out_vld,
    input  logic                out_ready,
    output hic_pkg::item_t      out_item
);

    logic            front_vld_reg;
    hic_pkg::item_t  front_item_reg;
    hic_pkg::item_t  item_next;
    logic signed [48:0] hs;
    logic [32:0]     d;
    logic [48:0]     wt_sum;

    assign s_ready = !front_vld_reg || out_ready;
    assign out_vld = front_vld_reg;
    assign out_item = front_item_reg;

    always_comb begin
        hs = {s_surface_level[47], s_surface_level} - {s_bed_level[47], s_bed_level};
        d = {1'b0, s_initial_rate} - {1'b0, s_sat_conductivity};
        wt_sum = {1'b0, s_wet_time} + 49'(time_step);
        item_next.info.skip = !enabled || s_weir_cell || (s_sat_conductivity == 32'd0)
                              || hs[48] || (hs == 49'sd0);
        item_next.info.z = s_surface_level;
        item_next.info.h = hs[47:0];
        item_next.info.ks = s_sat_conductivity;
        item_next.info.dneg = d[32];
        item_next.info.mag = d[32] ? 32'(-d) : d[31:0];
        item_next.info.wt = wt_sum[48] ? '1 : wt_sum[47:0];
        item_next.kd = s_decay_const;
        item_next.tw = s_wet_time;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else if (s_ready) begin
            front_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/hic_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hic_queue
// two-entry queue between front and back
// ---------------------------------------------------------------------------
module hic_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_vld,
    output logic            in_ready,
    input  hic_pkg::item_t  in_item,
    output logic            out_vld,
    input  logic            out_ready,
    output hic_pkg::item_t  out_item
);

    hic_pkg::item_t  mem_reg [0:1];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign in_ready = (count_reg != 2'd2);
    assign out_vld = (count_reg != 2'd0);
    assign out_item = mem_reg[rd_ptr_reg];
    assign push = in_vld && in_ready;
    assign pop = out_vld && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/hic_exp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hic_exp
// pipelined exp(-k*t) in q0.24: horner series then five squarings
// ---------------------------------------------------------------------------
module hic_exp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  hic_pkg::item_t  in_item,
    output logic            out_vld,
    output hic_pkg::cell_t  out_cell,
    output logic [24:0]     out_e
);

    logic                           m0_vld_reg;
    logic [55:0]                    m0_xa_reg;
    logic [55:0]                    m0_xb_reg;
    hic_pkg::cell_t                 m0_cell_reg;
    logic [hic_pkg::EXP_STAGES:0]   vld_reg;
    hic_pkg::exp_st_t               st_reg [0:hic_pkg::EXP_STAGES];
    hic_pkg::exp_st_t               st0_next;
    logic [79:0]                    x_sum;
    logic                           e_vld_reg;
    hic_pkg::cell_t                 e_cell_reg;
    logic [24:0]                    e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_xa_reg <= 56'(in_item.kd) * 56'(in_item.tw[23:0]);
            m0_xb_reg <= 56'(in_item.kd) * 56'(in_item.tw[47:24]);
            m0_cell_reg <= in_item.info;
        end
    end

    always_comb begin
        x_sum = {24'd0, m0_xa_reg} + {m0_xb_reg, 24'd0};
        st0_next.big = (x_sum >= hic_pkg::EXP_LIMIT);
        st0_next.u = x_sum[52:22];
        st0_next.acc = '0;
        st0_next.aux = hic_pkg::Q31_ONE;
        st0_next.info = m0_cell_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    for (genvar k = 0; k < hic_pkg::EXP_STAGES; k++) begin : g_stage
        hic_pkg::exp_st_t st_next;
        if (k < hic_pkg::HORNER_STAGES) begin : g_horner
            localparam int DIVISOR = hic_pkg::HORNER_TERMS - k / 3;
            if (k % 3 == 0) begin : g_mul
                always_comb begin
                    st_next = st_reg[k];
                    st_next.acc = 64'(st_reg[k].u) * 64'(st_reg[k].aux);
                end
            end else if (k % 3 == 1) begin : g_recip
                always_comb begin
                    st_next = st_reg[k];
                    st_next.aux = st_reg[k].acc[62:31];
                    st_next.acc = 64'(st_reg[k].acc[62:31])
                                  * 64'(hic_pkg::HORNER_RECIP[DIVISOR]);
                end
            end else begin : g_fix
                logic [31:0] q0;
                logic [35:0] rem;
                always_comb begin
                    q0 = st_reg[k].acc[63:32];
                    rem = 36'(st_reg[k].aux) - 36'(q0) * 36'(DIVISOR);
                    st_next = st_reg[k];
                    st_next.aux = hic_pkg::Q31_ONE
                                  - ((rem >= 36'(DIVISOR)) ? q0 + 32'd1 : q0);
                end
            end
        end else if ((k - hic_pkg::HORNER_STAGES) % 2 == 0) begin : g_sq
            always_comb begin
                st_next = st_reg[k];
                st_next.acc = 64'(st_reg[k].aux) * 64'(st_reg[k].aux);
            end
        end else begin : g_rnd
            always_comb begin
                st_next = st_reg[k];
                st_next.aux = 32'((st_reg[k].acc + 64'h4000_0000) >> 31);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m0_vld_reg <= 1'b0;
            vld_reg <= '0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            m0_vld_reg <= in_vld;
            vld_reg <= {vld_reg[hic_pkg::EXP_STAGES-1:0], m0_vld_reg};
            e_vld_reg <= vld_reg[hic_pkg::EXP_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_cell_reg <= st_reg[hic_pkg::EXP_STAGES].info;
            e_reg <= st_reg[hic_pkg::EXP_STAGES].big ? 25'd0
                     : 25'((33'(st_reg[hic_pkg::EXP_STAGES].aux) + 33'd64) >> 7);
        end
    end

    assign out_vld = e_vld_reg;
    assign out_cell = e_cell_reg;
    assign out_e = e_reg;

endmodule

// ===== rtl/core/hic_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hic_back
// rate, infiltration amount, surface update and rate division pipeline
// ---------------------------------------------------------------------------
module hic_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         time_step,
    input  logic [24:0]         dry_depth,
    input  logic                in_vld,
    output logic                in_ready,
    input  hic_pkg::item_t      in_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_updated,
    output logic signed [47:0]  m_new_surface,
    output logic [46:0]         m_new_depth,
    output logic                m_is_dry,
    output logic [31:0]         m_infil_rate,
    output logic [47:0]         m_new_wet_time
);

    logic                          adv;
    logic                          e_vld;
    hic_pkg::cell_t                e_cell;
    logic [24:0]                   e_val;

    logic                          b1_vld_reg;
    logic [56:0]                   b1_prod_reg;
    hic_pkg::cell_t                b1_cell_reg;
    logic                          b2_vld_reg;
    logic [31:0]                   b2_f_reg;
    hic_pkg::cell_t                b2_cell_reg;
    logic                          b3_vld_reg;
    logic [63:0]                   b3_prod_reg;
    hic_pkg::cell_t                b3_cell_reg;
    logic                          b4_vld_reg;
    logic [35:0]                   b4_infil_reg;
    hic_pkg::cell_t                b4_cell_reg;

    logic [31:0]                   m_next;
    logic [35:0]                   amount;
    logic [47:0]                   depth;
    logic [64:0]                   num;
    hic_pkg::div_st_t              d0_next;

    logic [hic_pkg::DIV_STEPS:0]   d_vld_reg;
    hic_pkg::div_st_t              d_reg [0:hic_pkg::DIV_STEPS];

    logic                          o_vld_reg;
    logic                          o_updated_reg;
    logic [47:0]                   o_surface_reg;
    logic [46:0]                   o_depth_reg;
    logic                          o_dry_reg;
    logic [31:0]                   o_rate_reg;
    logic [47:0]                   o_wt_reg;
    hic_pkg::div_st_t              o_src;

    assign adv = !o_vld_reg || m_ready;
    assign in_ready = adv;

    hic_exp u_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (in_vld),
        .in_item  (in_item),
        .out_vld  (e_vld),
        .out_cell (e_cell),
        .out_e    (e_val)
    );

    always_comb begin
        m_next = 32'((b1_prod_reg + 57'd8388608) >> 24);
        amount = 36'((65'(b3_prod_reg) + 65'h800_0000) >> 28);
        depth = b4_cell_reg.h - 48'(b4_infil_reg);
        num = {1'b0, b4_infil_reg, 28'd0} + 65'(time_step >> 1);
        d0_next.rem = num[64:33];
        d0_next.num = num[32:0];
        d0_next.quo = '0;
        d0_next.skip = b4_cell_reg.skip;
        d0_next.sat = (b4_infil_reg >= {time_step, 4'd0});
        d0_next.surf = 48'(b4_cell_reg.z) - 48'(b4_infil_reg);
        d0_next.depth = depth[47] ? '1 : depth[46:0];
        d0_next.dry = (depth <= 48'(dry_depth));
        d0_next.wt = b4_cell_reg.wt;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_prod_reg <= 57'(e_cell.mag) * 57'(e_val);
            b1_cell_reg <= e_cell;
            b2_f_reg <= b1_cell_reg.dneg ? b1_cell_reg.ks - m_next
                        : b1_cell_reg.ks + m_next;
            b2_cell_reg <= b1_cell_reg;
            b3_prod_reg <= 64'(b2_f_reg) * 64'(time_step);
            b3_cell_reg <= b2_cell_reg;
            b4_infil_reg <= ({12'd0, amount} < b3_cell_reg.h) ? amount
                            : b3_cell_reg.h[35:0];
            b4_cell_reg <= b3_cell_reg;
            d_reg[0] <= d0_next;
        end
    end

    for (genvar j = 0; j < hic_pkg::DIV_STEPS; j++) begin : g_div
        logic [32:0]       trial;
        logic              ge;
        hic_pkg::div_st_t  d_next;
        always_comb begin
            trial = {d_reg[j].rem, d_reg[j].num[32]};
            ge = (trial >= {1'b0, time_step});
            d_next = d_reg[j];
            d_next.rem = ge ? 32'(trial - {1'b0, time_step}) : trial[31:0];
            d_next.num = {d_reg[j].num[31:0], 1'b0};
            d_next.quo = {d_reg[j].quo[31:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                d_reg[j+1] <= d_next;
            end
        end
    end

    assign o_src = d_reg[hic_pkg::DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
            d_vld_reg <= '0;
            o_vld_reg <= 1'b0;
        end else if (adv) begin
            b1_vld_reg <= e_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
            d_vld_reg <= {d_vld_reg[hic_pkg::DIV_STEPS-1:0], b4_vld_reg};
            o_vld_reg <= d_vld_reg[hic_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (o_src.skip) begin
                o_updated_reg <= 1'b0;
                o_surface_reg <= '0;
                o_depth_reg <= '0;
                o_dry_reg <= 1'b0;
                o_rate_reg <= '0;
                o_wt_reg <= '0;
            end else begin
                o_updated_reg <= 1'b1;
                o_surface_reg <= o_src.surf;
                o_depth_reg <= o_src.depth;
                o_dry_reg <= o_src.dry;
                o_wt_reg <= o_src.wt;
                if (time_step == 32'd0) begin
                    o_rate_reg <= '0;
                end else if (o_src.sat || o_src.quo[32]) begin
                    o_rate_reg <= '1;
                end else begin
                    o_rate_reg <= o_src.quo[31:0];
                end
            end
        end
    end

    assign m_valid = o_vld_reg;
    assign m_updated = o_updated_reg;
    assign m_new_surface = o_surface_reg;
    assign m_new_depth = o_depth_reg;
    assign m_is_dry = o_dry_reg;
    assign m_infil_rate = o_rate_reg;
    assign m_new_wet_time = o_wt_reg;

endmodule

// ===== rtl/core/horton_infiltration_cell_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// horton_infiltration_cell_core
// one timestep of horton infiltration per grid cell beat
// ---------------------------------------------------------------------------
// usage:
//   s_* carries one cell per beat (valid/ready), m_* returns one result per
//   cell in order. cfg_wr_en/cfg_index/cfg_data write enabled, time_step and
//   dry_depth; write them only while no cell is in flight.
//   an accepted beat passes the front register, the queue, the exp pipeline
//   (product, horner series of twelve three-stage steps, five squarings,
//   output), the rate and amount stages, the rate division (one quotient
//   bit per stage) and the output register to m_valid. throughput is one cell
//   per cycle while m_ready is high, set by the fully pipelined back end. when
//   m_ready is low the back pipeline holds as a whole; the two-entry queue and
//   the front register keep taking beats until they fill.
//   reset (aresetn low, synchronous) empties every stage and restores the
//   register defaults: disabled, dt of one second, dry depth near 1 mm.
// ---------------------------------------------------------------------------
`include "horton_infiltration_cell_core_macros.svh"

module horton_infiltration_cell_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [47:0]  s_surface_level,
    input  logic signed [47:0]  s_bed_level,
    input  logic [31:0]         s_sat_conductivity,
    input  logic [31:0]         s_initial_rate,
    input  logic [31:0]         s_decay_const,
    input  logic [47:0]         s_wet_time,
    input  logic                s_weir_cell,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_updated,
    output logic signed [47:0]  m_new_surface,
    output logic [46:0]         m_new_depth,
    output logic                m_is_dry,
    output logic [31:0]         m_infil_rate,
    output logic [47:0]         m_new_wet_time
);

    logic            enabled_reg;
    logic [31:0]     time_step_reg;
    logic [24:0]     dry_depth_reg;

    logic            f_vld;
    logic            q_in_ready;
    hic_pkg::item_t  f_item;
    logic            q_vld;
    logic            b_ready;
    hic_pkg::item_t  q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            time_step_reg <= 32'd65536;
            dry_depth_reg <= 25'd16777;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hic_pkg::CFG_ENABLED: begin
                    enabled_reg <= cfg_data[0];
                end
                hic_pkg::CFG_TIME_STEP: begin
                    time_step_reg <= cfg_data;
                end
                hic_pkg::CFG_DRY_DEPTH: begin
                    dry_depth_reg <= cfg_data[24:0];
                end
                default: begin
                end
            endcase
        end
    end

    hic_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .enabled            (enabled_reg),
        .time_step          (time_step_reg),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_surface_level    (s_surface_level),
        .s_bed_level        (s_bed_level),
        .s_sat_conductivity (s_sat_conductivity),
        .s_initial_rate     (s_initial_rate),
        .s_decay_const      (s_decay_const),
        .s_wet_time         (s_wet_time),
        .s_weir_cell        (s_weir_cell),
        .out_vld            (f_vld),
        .out_ready          (q_in_ready),
        .out_item           (f_item)
    );

    hic_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_vld    (f_vld),
        .in_ready  (q_in_ready),
        .in_item   (f_item),
        .out_vld   (q_vld),
        .out_ready (b_ready),
        .out_item  (q_item)
    );

    hic_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .time_step      (time_step_reg),
        .dry_depth      (dry_depth_reg),
        .in_vld         (q_vld),
        .in_ready       (b_ready),
        .in_item        (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_updated      (m_updated),
        .m_new_surface  (m_new_surface),
        .m_new_depth    (m_new_depth),
        .m_is_dry       (m_is_dry),
        .m_infil_rate   (m_infil_rate),
        .m_new_wet_time (m_new_wet_time)
    );

    `HIC_ASSERT_IMP(a_skip_zero, m_valid && !m_updated, (m_new_surface == 48'sd0) && (m_new_depth == 47'd0) && !m_is_dry && (m_infil_rate == 32'd0) && (m_new_wet_time == 48'd0))
    `HIC_ASSERT_IMP(a_dry_flag, m_valid && m_updated, m_is_dry == (m_new_depth <= 47'(dry_depth_reg)))
    `HIC_ASSERT_IMP(a_zero_dt_rate, m_valid && m_updated && (time_step_reg == 32'd0), m_infil_rate == 32'd0)
    `HIC_ASSERT_NXT(a_front_hold, f_vld && !q_in_ready, f_vld)

endmodule

// ===== tb/tb_horton_infiltration_cell_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_horton_infiltration_cell_core
// self-checking bench for the horton infiltration cell core: cells are
// streamed through several register settings and idle/stall mixes, and an
// in-bench infiltration predictor checks every returned beat in order
// ---------------------------------------------------------------------------
module tb_horton_infiltration_cell_core;

    localparam int           CYCLE_LIMIT = 400000;
    localparam int           DRAIN_WAIT  = 120;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam longint unsigned M47 = 64'h7FFF_FFFF_FFFF;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic signed [47:0] surf;
        logic signed [47:0] bed;
        logic [31:0]        ks;
        logic [31:0]        f0;
        logic [31:0]        kd;
        logic [47:0]        tw;
        logic               weir;
    } cell_beat_t;

    typedef struct {
        logic               updated;
        logic signed [47:0] surf;
        logic [46:0]        depth;
        logic               dry;
        logic [31:0]        rate;
        logic [47:0]        wt;
    } cell_result_t;

    class infil_scoreboard;
        cell_result_t    pending_q[$];
        bit              en;
        longint unsigned dt;
        longint unsigned dry_thr;
        int              errors;

        function new();
            en = 0;
            dt = 65536;
            dry_thr = 16777;
            errors = 0;
        endfunction

        function void set_reg(hic_pkg::cfg_idx_t idx, logic [31:0] val);
            case (idx)
                hic_pkg::CFG_ENABLED:   en = val[0];
                hic_pkg::CFG_TIME_STEP: dt = 64'(val);
                hic_pkg::CFG_DRY_DEPTH: dry_thr = 64'(val[24:0]);
                default: ;
            endcase
        endfunction

        // exp(-k*t) in q0.24
        function longint unsigned decay_q24(longint unsigned k, longint unsigned t);
            longint unsigned lim, x, u, r;
            lim = 64'd24 << 48;
            if (t != 0 && k >= (lim + t - 1) / t)
                return 64'd0;
            x = k * t;
            u = x >> 22;
            r = 64'h8000_0000;
            for (int i = 12; i >= 1; i--)
                r = 64'h8000_0000 - (u * r) / (64'(i) << 31);
            for (int i = 0; i < 5; i++)
                r = (r * r + (64'd1 << 30)) >> 31;
            return (r + 64) >> 7;
        endfunction

        function void note_cell(cell_beat_t c);
            cell_result_t    res;
            longint          zs, zbs, hs, d;
            longint unsigned h, e, mag, m, f, amount, infil, depth, rate, wt;
            zs = c.surf;
            zbs = c.bed;
            hs = zs - zbs;
            res = '{default: '0};
            if (en && !c.weir && c.ks != 0 && hs > 0) begin
                h = hs;
                e = decay_q24(64'(c.kd), 64'(c.tw));
                d = longint'(c.f0) - longint'(c.ks);
                mag = d < 0 ? -d : d;
                m = (mag * e + (64'd1 << 23)) >> 24;
                f = d < 0 ? 64'(c.ks) - m : 64'(c.ks) + m;
                amount = (f * dt + (64'd1 << 27)) >> 28;
                infil = amount < h ? amount : h;
                depth = h - infil;
                if (dt == 0) begin
                    rate = 0;
                end else if (infil >= 16 * dt) begin
                    rate = M32;
                end else begin
                    rate = ((infil << 28) + dt / 2) / dt;
                    if (rate > M32)
                        rate = M32;
                end
                wt = 64'(c.tw) + dt;
                if (wt > M48)
                    wt = M48;
                res.updated = 1;
                res.surf = 48'(zs - longint'(infil));
                res.depth = 47'(depth > M47 ? M47 : depth);
                res.dry = depth <= dry_thr;
                res.rate = 32'(rate);
                res.wt = 48'(wt);
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(cell_result_t act);
            cell_result_t exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (act.updated !== exp_r.updated) begin
                $display("%0t: updated exp %h act %h", $time, exp_r.updated, act.updated);
                errors++;
            end
            if (act.surf !== exp_r.surf) begin
                $display("%0t: new_surface exp %h act %h", $time, exp_r.surf, act.surf);
                errors++;
            end
            if (act.depth !== exp_r.depth) begin
                $display("%0t: new_depth exp %h act %h", $time, exp_r.depth, act.depth);
                errors++;
            end
            if (act.dry !== exp_r.dry) begin
                $display("%0t: is_dry exp %h act %h", $time, exp_r.dry, act.dry);
                errors++;
            end
            if (act.rate !== exp_r.rate) begin
                $display("%0t: infil_rate exp %h act %h", $time, exp_r.rate, act.rate);
                errors++;
            end
            if (act.wt !== exp_r.wt) begin
                $display("%0t: new_wet_time exp %h act %h", $time, exp_r.wt, act.wt);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_wr_en = 0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [47:0] s_surface_level = '0;
    logic signed [47:0] s_bed_level = '0;
    logic [31:0]        s_sat_conductivity = '0;
    logic [31:0]        s_initial_rate = '0;
    logic [31:0]        s_decay_const = '0;
    logic [47:0]        s_wet_time = '0;
    logic               s_weir_cell = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic               m_updated;
    logic signed [47:0] m_new_surface;
    logic [46:0]        m_new_depth;
    logic               m_is_dry;
    logic [31:0]        m_infil_rate;
    logic [47:0]        m_new_wet_time;

    infil_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              cycle_count = 0;

    horton_infiltration_cell_core uut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cell_beat_t   c;
        cell_result_t r;
        if (aresetn && s_valid && s_ready) begin
            c.surf = s_surface_level;
            c.bed = s_bed_level;
            c.ks = s_sat_conductivity;
            c.f0 = s_initial_rate;
            c.kd = s_decay_const;
            c.tw = s_wet_time;
            c.weir = s_weir_cell;
            sb.note_cell(c);
        end
        if (aresetn && m_valid && m_ready) begin
            r.updated = m_updated;
            r.surf = m_new_surface;
            r.depth = m_new_depth;
            r.dry = m_is_dry;
            r.rate = m_infil_rate;
            r.wt = m_new_wet_time;
            sb.check_result(r);
        end
    end

    function automatic longint unsigned rand_bits(int bits);
        longint unsigned v;
        v = {$urandom, $urandom};
        return bits == 0 ? 64'd0 : v >> (64 - bits);
    endfunction

    // random width so values spread over many magnitudes
    function automatic longint unsigned rand_mag(int maxbits);
        return rand_bits(int'($urandom_range(maxbits)));
    endfunction

    function automatic cell_beat_t rand_cell();
        cell_beat_t c;
        longint     h;
        c.surf = 48'(rand_bits(48));
        if ($urandom_range(99) < 15) begin
            c.bed = 48'(rand_bits(48));
            c.ks = 32'(rand_bits(32));
            c.f0 = 32'(rand_bits(32));
            c.kd = 32'(rand_bits(32));
            c.tw = 48'(rand_bits(48));
            c.weir = 1'($urandom_range(1));
        end else begin
            h = rand_mag(40) + 1;
            c.bed = 48'(c.surf - h);
            c.ks = 32'(rand_mag(32));
            if (c.ks == 0)
                c.ks = 1;
            c.f0 = 32'($urandom_range(1) ? rand_mag(32) : rand_bits(32));
            c.kd = 32'(rand_mag(32));
            c.tw = 48'($urandom_range(9) == 0 ? M48 - rand_mag(36) : rand_mag(48));
            c.weir = ($urandom_range(19) == 0);
        end
        return c;
    endfunction

    task automatic write_reg(hic_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_cell(cell_beat_t c);
        s_valid <= 1;
        s_surface_level <= c.surf;
        s_bed_level <= c.bed;
        s_sat_conductivity <= c.ks;
        s_initial_rate <= c.f0;
        s_decay_const <= c.kd;
        s_wet_time <= c.tw;
        s_weir_cell <= c.weir;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_regs(bit en, logic [31:0] dt, logic [31:0] dry);
        write_reg(hic_pkg::CFG_ENABLED, 32'(en));
        write_reg(hic_pkg::CFG_TIME_STEP, dt);
        write_reg(hic_pkg::CFG_DRY_DEPTH, dry);
    endtask

    task automatic run_random(int n, int idle, int stall, bit hold_off);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if (hold_off && i == n / 2) begin
                s_valid <= 0;
                while (sb.pending_q.size() != 0)
                    @(posedge aclk);
            end
            send_cell(rand_cell());
        end
    endtask

    task automatic run_directed();
        cell_beat_t c;
        cell_beat_t base;
        base = '{surf: 48'sd16777216, bed: 48'sd0, ks: 32'd1000000, f0: 32'd50000000,
                 kd: 32'd1 << 28, tw: 48'd65536, weir: 0};
        send_cell(base);
        c = base; c.weir = 1; send_cell(c);
        c = base; c.ks = 0; send_cell(c);
        c = base; c.bed = c.surf; send_cell(c);
        c = base; c.bed = c.surf + 48'sd5; send_cell(c);
        c = base; c.surf = 48'sh7FFF_FFFF_FFFF; c.bed = 48'sh8000_0000_0000; send_cell(c);
        c = base; c.surf = 48'sh8000_0000_0000; c.bed = 48'sh8000_0000_0000 - 48'sd1;
        send_cell(c);
        c = base; c.tw = 48'(M48); send_cell(c);
        c = base; c.kd = '1; c.tw = 48'(M48); send_cell(c);
        c = base; c.kd = '1; c.tw = 48'd24 << 16; send_cell(c);
        c = base; c.kd = '1; c.tw = (48'd24 << 16) - 48'd1; send_cell(c);
        c = base; c.kd = 0; send_cell(c);
        c = base; c.tw = 0; send_cell(c);
        c = base; c.f0 = 0; send_cell(c);
        c = base; c.f0 = c.ks; send_cell(c);
        c = base; c.ks = '1; c.f0 = '1; send_cell(c);
        c = base; c.ks = '1; c.f0 = 0; c.kd = 0; send_cell(c);
        c = base; c.ks = 1; c.f0 = '1; send_cell(c);
        c = base; c.bed = c.surf - 48'sd1; send_cell(c);
        c = base; c.bed = c.surf - 48'sd16777; send_cell(c);
        c = base; c.ks = '1; c.f0 = '1; c.bed = c.surf - 48'sd1000000000; send_cell(c);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset registers: block disabled
        run_directed();
        drain();
        set_regs(1'b1, 32'd65536, 32'd16777);
        run_directed();
        run_random(64, 0, 0, 0);
        drain();
        set_regs(1'b1, 32'd1, 32'd0);
        run_directed();
        run_random(56, 49, 0, 1);
        drain();
        set_regs(1'b1, 32'hFFFF_FFFF, 32'd16777216);
        run_directed();
        run_random(56, 0, 49, 0);
        drain();
        set_regs(1'b1, 32'(rand_bits(32) | 64'd1), 32'($urandom_range(16777216)));
        run_random(64, 12, 12, 0);
        drain();
        set_regs(1'b1, 32'd1 << $urandom_range(24), 32'($urandom_range(16777216)));
        run_random(64, 49, 49, 0);
        drain();
        write_reg(hic_pkg::CFG_ENABLED, 32'd0);
        run_random(32, 12, 12, 0);
        drain();
        write_reg(hic_pkg::CFG_ENABLED, 32'd1);
        run_random(30, 0, 0, 0);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
